// ----- rtl/core/bfa_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the bitmap frame allocator.
// No dependencies.
package bfa_pkg;

  localparam int NUM_BLOCKS = 4096;
  localparam int BLOCK_SIZE = 4096;
  localparam int WORD_BITS  = 32;
  localparam int WORDS      = NUM_BLOCKS / WORD_BITS;
  localparam int WORD_AW    = $clog2(WORDS);
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int BS_SHIFT   = $clog2(BLOCK_SIZE);
  localparam int CNT_W      = 13;
  localparam int LIM_W      = WORD_AW + 1;

  typedef enum logic [1:0] {
    ACT_ALLOC    = 2'd0,
    ACT_FREE     = 2'd1,
    ACT_REG_FREE = 2'd2,
    ACT_REG_USED = 2'd3
  } action_t;

  typedef struct packed {
    logic               clear;
    logic               step;
    logic [7:0]         bits;
    logic [BLK_W-1:0]   base;
    logic [CNT_W-1:0]   need;
  } scan_ctl_t;

endpackage

// ----- rtl/core/bfa_bitmap.sv -----
`timescale 1ns / 1ps
// Usage bitmap store: one 32-bit word per address, registered read.
// Entries never written read as all ones. Depends on bfa_pkg.
module bfa_bitmap import bfa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  logic [WORD_AW-1:0] rd_addr,
  output logic [31:0]        rd_data,
  input  logic               wr_en,
  input  logic [WORD_AW-1:0] wr_addr,
  input  logic [31:0]        wr_data
);

  logic [31:0]      mem [WORDS];
  logic [31:0]      mem_q;
  logic [WORDS-1:0] valid;
  logic             valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q   <= mem[rd_addr];
      valid_q <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = valid_q ? mem_q : '1;

endmodule

// ----- rtl/core/bfa_scan.sv -----
`timescale 1ns / 1ps
// Free-run scanner: walks eight bitmap bits per step, tracking the run length.
// Depends on bfa_pkg.
module bfa_scan import bfa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  scan_ctl_t        ctl,
  output logic             hit,
  output logic [BLK_W-1:0] hit_pos
);

  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] run_next;

  always_comb begin
    run_next = run;
    hit      = 1'b0;
    hit_pos  = ctl.base;
    for (int i = 0; i < 8; i++) begin
      if (!hit) begin
        if (ctl.bits[i]) begin
          run_next = '0;
        end else begin
          run_next = run_next + CNT_W'(1);
          if (run_next == ctl.need) begin
            hit     = 1'b1;
            hit_pos = ctl.base + BLK_W'(i);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      run <= '0;
    end else if (ctl.step) begin
      run <= run_next;
    end
  end

endmodule

// ----- rtl/core/bitmap_frame_allocator_core.sv -----
`timescale 1ns / 1ps
// Bitmap frame allocator top: sequencer, used-block counter, result registers.
// Depends on bfa_pkg, bfa_bitmap, bfa_scan.
//
// Usage:
//   Issue a request by raising start while busy is low; action, address and
//   amount are sampled at that edge. busy stays high until the result is out.
//   The result appears on block_address, success and used_blocks for one
//   cycle with done high; the receiver cannot stall, so take it then.
//   total_blocks is written through cfg_valid/cfg_ready/cfg_data; the user must
//   write it only while idle, as the block does not enforce it; cfg_ready is always high.
// Steps, one request at a time:
//   Free and region: setup, clip, then a read and a write per bitmap word
//   touched, plus a read and write of word 0 (block 0 fixup) on region
//   requests; an ignored free or a refused allocate goes from setup to the result.
//   Allocate: setup, then per 32-block word a word read and eight bits a cycle
//   through the run scanner, then a read and a write per word marked.
// Reset:
//   All blocks read as used, used_blocks is 4096, total_blocks is 4096;
//   the first request is taken right away.
module bitmap_frame_allocator_core import bfa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action,
  input  logic [31:0]      address,
  input  logic [31:0]      amount,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output logic             done,
  output logic [31:0]      block_address,
  output logic             success,
  output logic [CNT_W-1:0] used_blocks
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SETUP     = 8'b0000_0010,
    S_CLIP      = 8'b0000_0100,
    S_SCAN_RD   = 8'b0000_1000,
    S_SCAN_BYTE = 8'b0001_0000,
    S_W_RD      = 8'b0010_0000,
    S_W_WR      = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_t;

  state_t state;

  logic [1:0]             act_q;
  logic [31:0]            addr_q;
  logic [31:0]            amt_q;
  logic [CNT_W-1:0]       total_blocks;
  logic [CNT_W-1:0]       used_count;
  logic [31-BS_SHIFT:0]   first_q;
  logic [31:0]            n_q;
  logic [BLK_W-1:0]       run_lo;
  logic [BLK_W-1:0]       run_hi;
  logic                   set_q;
  logic                   force0;
  logic [WORD_AW-1:0]     word_idx;
  logic [1:0]             byte_idx;
  logic [LIM_W-1:0]       limit;

  logic [CNT_W-1:0]       eff_total;
  logic [CNT_W-1:0]       free_cnt;
  logic [32:0]            cnt_sum;
  logic [CNT_W-1:0]       cnt_add;
  logic [CNT_W-1:0]       cnt_sub;
  logic [31:0]            cnt_n;
  logic [CNT_W-1:0]       avail;
  logic [31:0]            n_clip;
  logic [BLK_W:0]         start_blk;

  logic                   rd_en;
  logic [WORD_AW-1:0]     rd_addr;
  logic [31:0]            rd_data;
  logic                   wr_en;
  logic [31:0]            wr_data;
  logic [31:0]            mask;
  logic [4:0]             lo_bit;
  logic [4:0]             hi_bit;

  scan_ctl_t              scan_ctl;
  logic                   hit;
  logic [BLK_W-1:0]       hit_pos;

  assign busy        = (state != S_IDLE);
  assign done        = (state == S_DONE);
  assign cfg_ready   = 1'b1;
  assign used_blocks = used_count;

  assign eff_total = (total_blocks < CNT_W'(NUM_BLOCKS)) ? total_blocks : CNT_W'(NUM_BLOCKS);
  assign free_cnt  = (eff_total > used_count) ? eff_total - used_count : '0;

  // Shared saturating counter unit; amount source depends on the step.
  always_comb begin
    if (state == S_SCAN_BYTE) begin
      cnt_n = amt_q;
    end else if (act_q == ACT_FREE) begin
      cnt_n = amt_q;
    end else begin
      cnt_n = 32'(amt_q >> BS_SHIFT);
    end
  end
  assign cnt_sum = {20'd0, used_count} + {1'b0, cnt_n};
  assign cnt_add = (cnt_sum > {20'd0, eff_total}) ? eff_total : cnt_sum[CNT_W-1:0];
  assign cnt_sub = (cnt_n >= {19'd0, used_count}) ? '0 : used_count - cnt_n[CNT_W-1:0];

  assign avail  = CNT_W'(NUM_BLOCKS) - CNT_W'(first_q);
  assign n_clip = (n_q > {19'd0, avail}) ? {19'd0, avail} : n_q;

  assign start_blk = {1'b0, hit_pos} + (BLK_W+1)'(1) - amt_q[BLK_W:0];

  always_comb begin
    scan_ctl.clear = (state == S_SETUP);
    scan_ctl.step  = (state == S_SCAN_BYTE);
    scan_ctl.bits  = rd_data[8*byte_idx +: 8];
    scan_ctl.base  = {word_idx, byte_idx, 3'b000};
    scan_ctl.need  = amt_q[CNT_W-1:0];
  end

  bfa_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctl     (scan_ctl),
    .hit     (hit),
    .hit_pos (hit_pos)
  );

  assign lo_bit  = (word_idx == run_lo[BLK_W-1:5]) ? run_lo[4:0] : 5'd0;
  assign hi_bit  = (word_idx == run_hi[BLK_W-1:5]) ? run_hi[4:0] : 5'd31;
  assign mask    = ({32{1'b1}} << lo_bit) & ({32{1'b1}} >> (5'd31 - hi_bit));
  assign wr_data = set_q ? (rd_data | mask) : (rd_data & ~mask);
  assign wr_en   = (state == S_W_WR);
  assign rd_en   = (state == S_SCAN_RD) || (state == S_W_RD);
  assign rd_addr = word_idx;

  bfa_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (word_idx),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= CNT_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      total_blocks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= CNT_W'(NUM_BLOCKS);
      force0     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            act_q         <= action;
            addr_q        <= address;
            amt_q         <= amount;
            block_address <= '0;
            success       <= 1'b1;
            force0        <= 1'b0;
            state         <= S_SETUP;
          end
        end
        S_SETUP: begin
          word_idx <= '0;
          byte_idx <= '0;
          limit    <= LIM_W'(eff_total >> 5);
          case (act_q)
            ACT_ALLOC: begin
              if (amt_q == '0 || amt_q > {19'd0, free_cnt} || (eff_total >> 5) == '0) begin
                success <= 1'b0;
                state   <= S_DONE;
              end else begin
                state <= S_SCAN_RD;
              end
            end
            ACT_FREE: begin
              if (amt_q == 32'd1 && addr_q == '0) begin
                state <= S_DONE;
              end else begin
                first_q    <= addr_q[31:BS_SHIFT];
                n_q        <= amt_q;
                set_q      <= 1'b0;
                used_count <= cnt_sub;
                state      <= S_CLIP;
              end
            end
            default: begin
              first_q    <= addr_q[31:BS_SHIFT];
              n_q        <= 32'(amt_q >> BS_SHIFT);
              set_q      <= (act_q == ACT_REG_USED);
              used_count <= (act_q == ACT_REG_USED) ? cnt_add : cnt_sub;
              force0     <= 1'b1;
              state      <= S_CLIP;
            end
          endcase
        end
        S_CLIP: begin
          if ({12'd0, first_q} >= 32'(NUM_BLOCKS) || n_q == '0) begin
            if (force0) begin
              force0   <= 1'b0;
              set_q    <= 1'b1;
              run_lo   <= '0;
              run_hi   <= '0;
              word_idx <= '0;
              state    <= S_W_RD;
            end else begin
              state <= S_DONE;
            end
          end else begin
            run_lo   <= first_q[BLK_W-1:0];
            run_hi   <= first_q[BLK_W-1:0] + n_clip[BLK_W-1:0] - BLK_W'(1);
            word_idx <= first_q[BLK_W-1:5];
            state    <= S_W_RD;
          end
        end
        S_SCAN_RD: begin
          byte_idx <= '0;
          state    <= S_SCAN_BYTE;
        end
        S_SCAN_BYTE: begin
          if (hit) begin
            run_lo        <= start_blk[BLK_W-1:0];
            run_hi        <= hit_pos;
            word_idx      <= start_blk[BLK_W-1:5];
            set_q         <= 1'b1;
            used_count    <= cnt_add;
            block_address <= 32'({start_blk[BLK_W-1:0], {BS_SHIFT{1'b0}}});
            state         <= S_W_RD;
          end else if (byte_idx == 2'd3) begin
            if (({1'b0, word_idx} + LIM_W'(1)) == limit) begin
              success <= 1'b0;
              state   <= S_DONE;
            end else begin
              word_idx <= word_idx + WORD_AW'(1);
              state    <= S_SCAN_RD;
            end
          end else begin
            byte_idx <= byte_idx + 2'd1;
          end
        end
        S_W_RD: begin
          state <= S_W_WR;
        end
        S_W_WR: begin
          if (word_idx != run_hi[BLK_W-1:5]) begin
            word_idx <= word_idx + WORD_AW'(1);
            state    <= S_W_RD;
          end else if (force0) begin
            // block 0 always ends up used after a region request
            force0   <= 1'b0;
            set_q    <= 1'b1;
            run_lo   <= '0;
            run_hi   <= '0;
            word_idx <= '0;
            state    <= S_W_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("no return to idle after result");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (done && !success) |-> (block_address == '0))
    else $error("failed allocation carries an address");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(NUM_BLOCKS))
    else $error("used count above block total");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $past(state) == S_W_RD)
    else $error("bitmap write without preceding read");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_frame_allocator_core: directed and random requests,
// predicted by a bit-accurate allocator model. Depends on bfa_pkg and the core RTL.
module tb_top;
  import bfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [31:0]      block_address;
    logic             success;
    logic [CNT_W-1:0] used_blocks;
  } alloc_result_t;

  typedef struct {
    int unsigned first;
    int unsigned count;
  } run_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       action = '0;
  logic [31:0]      address = '0;
  logic [31:0]      amount = '0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             done;
  logic [31:0]      block_address;
  logic             success;
  logic [CNT_W-1:0] used_blocks;

  bitmap_frame_allocator_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .address(address), .amount(amount),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .block_address(block_address), .success(success),
    .used_blocks(used_blocks)
  );

  always #4 clk = ~clk;

  // allocator shadow state
  logic [NUM_BLOCKS-1:0] shadow_map;
  int unsigned           shadow_used;
  int unsigned           shadow_total;

  alloc_result_t pending_results[$];
  run_t          live_runs[$];
  int            errors = 0;
  int            requests_sent = 0;
  int            results_seen = 0;
  int            allocs_granted = 0;
  int            idle_pct = 0;
  int            quiet_cycles = 0;

  function automatic int unsigned eff_total();
    return (shadow_total < NUM_BLOCKS) ? shadow_total : NUM_BLOCKS;
  endfunction

  function automatic void mark_run(longint unsigned first, longint unsigned n, logic val);
    if (first >= NUM_BLOCKS) return;
    if (n > NUM_BLOCKS - first) n = NUM_BLOCKS - first;
    for (longint unsigned i = 0; i < n; i++) shadow_map[first + i] = val;
  endfunction

  function automatic void count_up(longint unsigned n);
    longint unsigned sum;
    sum = shadow_used + n;
    shadow_used = (sum > eff_total()) ? eff_total() : 32'(sum);
  endfunction

  function automatic void count_down(longint unsigned n);
    shadow_used = (n >= shadow_used) ? 0 : 32'(shadow_used - n);
  endfunction

  function automatic alloc_result_t predict_request(action_t act, logic [31:0] addr,
                                                    logic [31:0] amt);
    alloc_result_t   res;
    int unsigned     tot, free_cnt, limit, run_len;
    longint unsigned first, n;
    res.block_address = '0;
    res.success = 1'b1;
    case (act)
      ACT_ALLOC: begin
        tot = eff_total();
        free_cnt = (tot > shadow_used) ? tot - shadow_used : 0;
        res.success = 1'b0;
        if (amt != 0 && amt <= free_cnt) begin
          limit = (tot / 32) * 32;
          run_len = 0;
          for (int unsigned b = 0; b < limit; b++) begin
            if (shadow_map[b]) begin
              run_len = 0;
            end else begin
              run_len++;
              if (run_len == amt) begin
                mark_run(b + 1 - run_len, amt, 1'b1);
                count_up(amt);
                res.block_address = (b + 1 - run_len) * BLOCK_SIZE;
                res.success = 1'b1;
                allocs_granted++;
                live_runs.push_back('{b + 1 - run_len, amt});
                break;
              end
            end
          end
        end
      end
      ACT_FREE: begin
        if (!(amt == 1 && addr == 0)) begin
          mark_run(addr / BLOCK_SIZE, amt, 1'b0);
          count_down(amt);
        end
      end
      default: begin
        first = addr / BLOCK_SIZE;
        n = amt / BLOCK_SIZE;
        if (act == ACT_REG_FREE) begin
          mark_run(first, n, 1'b0);
          count_down(n);
        end else begin
          mark_run(first, n, 1'b1);
          count_up(n);
        end
        shadow_map[0] = 1'b1;
      end
    endcase
    res.used_blocks = shadow_used[CNT_W-1:0];
    return res;
  endfunction

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("[%0t] %s: got %0h, expected %0h", $time, field, got, want);
    errors++;
  endtask

  // issue one request; start stays high unless an idle gap follows
  task automatic send_request(action_t act, logic [31:0] addr, logic [31:0] amt);
    action  <= act;
    address <= addr;
    amount  <= amt;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_request(act, addr, amt));
    requests_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic hold_off();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_total(int unsigned value);
    hold_off();
    cfg_data  <= value[CNT_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    shadow_total = value[CNT_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  // result checker: the receiver cannot stall, so take every strobe
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected result", block_address, 0);
      end else begin
        want = pending_results.pop_front();
        if (block_address !== want.block_address)
          report("block_address", block_address, want.block_address);
        if (success !== want.success) report("success", success, want.success);
        if (used_blocks !== want.used_blocks)
          report("used_blocks", used_blocks, want.used_blocks);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("bitmap_frame_allocator_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_reset_state();
    send_request(ACT_ALLOC, 32'h0, 32'd1);
  endtask

  task automatic test_edge_cases();
    send_request(ACT_REG_FREE, 32'h0, 32'hFFFF_FFFF);
    send_request(ACT_ALLOC, 32'h0, 32'd0);
    send_request(ACT_ALLOC, 32'hFFFF_FFFF, 32'd1);
    send_request(ACT_ALLOC, 32'h0, 32'd31);
    send_request(ACT_ALLOC, 32'h0, 32'd4097);
    send_request(ACT_ALLOC, 32'h0, 32'hFFFF_FFFF);
    send_request(ACT_FREE, 32'h0, 32'd1);
    send_request(ACT_FREE, 32'h0, 32'd0);
    send_request(ACT_FREE, 32'h0000_1FFF, 32'd1);
    send_request(ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_REG_USED, 32'h0000_1000, 32'h0000_3FFF);
    send_request(ACT_REG_USED, 32'h0, 32'hFFFF_FFFF);
    send_request(ACT_REG_FREE, 32'hFFFF_F000, 32'h0000_2000);
    send_request(ACT_REG_FREE, 32'h0, 32'h0100_0000);
    send_request(ACT_ALLOC, 32'h0, 32'd4096);
    send_request(ACT_ALLOC, 32'h0, 32'd4095);
    send_request(ACT_ALLOC, 32'h0, 32'd1);
    send_request(ACT_FREE, 32'h0000_1000, 32'd4095);
    send_request(ACT_REG_USED, 32'h0080_0000, 32'h0000_0FFF);
    send_request(ACT_REG_FREE, 32'h0, 32'h0);
    live_runs.delete();
  endtask

  task automatic test_random_mix(int unsigned total, int items, int pct);
    int   pick, idx;
    run_t r;
    write_total(total);
    idle_pct = pct;
    send_request(ACT_REG_FREE, 32'h0, 32'hFFFF_FFFF);
    live_runs.delete();
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      if (pick < 42) begin
        if ($urandom_range(9) == 0)
          send_request(ACT_ALLOC, $urandom, $urandom_range(1, 300));
        else
          send_request(ACT_ALLOC, $urandom, $urandom_range(1, 24));
      end else if (pick < 72 && live_runs.size() != 0) begin
        idx = $urandom_range(live_runs.size() - 1);
        r = live_runs[idx];
        live_runs.delete(idx);
        send_request(ACT_FREE, r.first * BLOCK_SIZE + $urandom_range(BLOCK_SIZE - 1), r.count);
      end else if (pick < 82) begin
        send_request($urandom_range(1) ? ACT_REG_FREE : ACT_REG_USED,
                     $urandom_range(NUM_BLOCKS - 1) * BLOCK_SIZE + $urandom_range(4095),
                     $urandom_range(0, 64 * BLOCK_SIZE));
      end else if (pick < 85) begin
        // free every block but block 0 so allocation stays busy
        send_request(ACT_REG_FREE, 32'h0, 32'hFFFF_FFFF);
        live_runs.delete();
      end else begin
        send_request(action_t'($urandom_range(3)), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    shadow_map = '1;
    shadow_total = 4096;
    shadow_used = 4096;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_edge_cases();
    test_random_mix(4096, 220, 0);
    test_random_mix(32, 150, 46);
    test_random_mix(4095, 180, 0);
    test_random_mix($urandom_range(33, 4094), 200, 21);
    test_random_mix(4096, 180, 46);
    hold_off();
    repeat (50) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d allocations granted", requests_sent,
             results_seen, allocs_granted);
    $display("block totals of 32, 4095, 4096 and a random size; %0d mismatches", errors);
    if (errors == 0 && pending_results.size() == 0)
      $display("bitmap_frame_allocator_core: match");
    else
      $display("bitmap_frame_allocator_core: mismatch");
    $finish;
  end

endmodule

// ----- bitmap_frame_allocator_core.f -----
rtl/core/bfa_pkg.sv
rtl/core/bfa_bitmap.sv
rtl/core/bfa_scan.sv
rtl/core/bitmap_frame_allocator_core.sv
verif/tb_top.sv
